[sv/rzs_pkg.sv]
// Shared widths, codes and the queue item type for the rolling z-score pair signal block.
// No dependencies; every other file imports this package.
package rzs_pkg;

	localparam int WINDOW_LEN = 8;
	localparam int WIN_IDX_W  = $clog2(WINDOW_LEN);
	localparam int FILL_W     = $clog2(WINDOW_LEN + 1);

	localparam int PRICE_W    = 24;
	localparam int SPREAD_W   = PRICE_W + 1;
	localparam int SQ_W       = 2 * PRICE_W;
	localparam int SUM_W      = SPREAD_W + WIN_IDX_W;
	localparam int SUMSQ_W    = SQ_W + WIN_IDX_W;
	localparam int D_W        = SUM_W + 1;
	localparam int V_W        = SUMSQ_W + WIN_IDX_W;

	localparam int THR_W      = 12;
	localparam int THR2_W     = 2 * THR_W;
	localparam int THR_FRAC   = 8;
	localparam int Z_SHIFT    = 2 * THR_FRAC;

	localparam int MUL_W      = 32;
	localparam int PROD_W     = 2 * MUL_W;
	localparam int V_HI_W     = V_W - MUL_W;
	localparam int CMP_W      = V_W + THR2_W;

	// queue depth must stay a power of two (pointers wrap naturally)
	localparam int Q_DEPTH    = 2;
	localparam int Q_PTR_W    = $clog2(Q_DEPTH);
	localparam int Q_CNT_W    = $clog2(Q_DEPTH + 1);

	localparam int CFG_IDX_W  = 1;
	localparam logic [CFG_IDX_W-1:0] REG_ENTRY = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_EXIT  = 1'd1;

	localparam logic [THR_W-1:0] ENTRY_RESET = 12'd256;
	localparam logic [THR_W-1:0] EXIT_RESET  = 12'd205;

	typedef enum logic [1:0] {
		SIG_LONG_SHORT = 2'd0,
		SIG_SHORT_LONG = 2'd1,
		SIG_CLOSE      = 2'd2,
		SIG_NONE       = 2'd3
	} sig_t;

	// one scored word: spread, deviation and the window sums before the update
	typedef struct packed {
		logic [SPREAD_W-1:0] spread;
		logic [D_W-1:0]      dev;
		logic [SUM_W-1:0]    sum;
		logic [SUMSQ_W-1:0]  sumsq;
	} rzs_item_t;

endpackage

[sv/rolling_zscore_pair_signal.sv]
// Top level of the rolling z-score pair signal block: configuration registers,
// front end, word queue and scoring back end. Depends on rzs_pkg and all rzs_* modules.
//
// Each accepted price pair forms spread = price_a - price_b. The first WINDOW_LEN pairs only
// fill the window and give no result; they are taken one per cycle. Every later pair gives one
// result: signal (long_short, short_long, close, none) and the spread, scored against the window
// as it stood before the pair. The front end takes one pair per cycle unless the queue is full
// and is two stages deep; scoring runs on one shared 32x32 multiplier in a sequence of states
// and takes a new word only when done with the last; the two-word queue holds pairs ahead of it.
// A result waits in the output register while the back end starts the next word. Thresholds
// are Q4.8; the user writes them only while the block is idle, which the block does not enforce.
module rolling_zscore_pair_signal (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [rzs_pkg::PRICE_W-1:0]   price_a,
	input  logic [rzs_pkg::PRICE_W-1:0]   price_b,
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [1:0]                    signal,
	output logic [rzs_pkg::SPREAD_W-1:0]  spread_value,
	input  logic                          cfg_we,
	input  logic [rzs_pkg::CFG_IDX_W-1:0] cfg_index,
	input  logic [rzs_pkg::THR_W-1:0]     cfg_data
);
	import rzs_pkg::*;

	logic [THR_W-1:0] entry_q;
	logic [THR_W-1:0] exit_q;
	logic             push;
	logic             pop;
	logic             q_full;
	logic             q_empty;
	rzs_item_t        push_item;
	rzs_item_t        head;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			entry_q <= ENTRY_RESET;
			exit_q  <= EXIT_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_ENTRY: entry_q <= cfg_data;
				REG_EXIT:  exit_q  <= cfg_data;
				default: ;
			endcase
		end
	end

	rzs_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.price_a   (price_a),
		.price_b   (price_b),
		.q_full    (q_full),
		.push      (push),
		.push_item (push_item)
	);

	rzs_fifo u_fifo (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_item (push_item),
		.pop       (pop),
		.head      (head),
		.full      (q_full),
		.empty     (q_empty)
	);

	rzs_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.head         (head),
		.q_empty      (q_empty),
		.pop          (pop),
		.entry_thr    (entry_q),
		.exit_thr     (exit_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.signal       (signal),
		.spread_value (spread_value)
	);

endmodule

[sv/rzs_front.sv]
// Front end: takes price pairs, forms the spread and its square, keeps the window and sums.
// Pushes one word per scored pair into the queue. Depends on rzs_pkg.
module rzs_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [rzs_pkg::PRICE_W-1:0] price_a,
	input  logic [rzs_pkg::PRICE_W-1:0] price_b,
	input  logic                      q_full,
	output logic                      push,
	output rzs_pkg::rzs_item_t        push_item
);
	import rzs_pkg::*;

	logic                       advance;
	logic                       commit;
	logic                       filled;
	logic                       valid_s1;
	logic                       valid_s2;
	logic signed [SPREAD_W-1:0] spread_s1;
	logic signed [SPREAD_W-1:0] spread_s2;
	logic [SQ_W-1:0]            sq_s2;
	logic [PRICE_W-1:0]         mag_s1;
	logic signed [SPREAD_W-1:0] win_spread_q [WINDOW_LEN];
	logic [SQ_W-1:0]            win_sq_q [WINDOW_LEN];
	logic [FILL_W-1:0]          fill_q;
	logic signed [SUM_W-1:0]    sum_q;
	logic [SUMSQ_W-1:0]         sumsq_q;
	logic signed [SUM_W-1:0]    sum_d;
	logic [SUMSQ_W-1:0]         sumsq_d;
	logic signed [D_W-1:0]      dev;

	assign advance  = !q_full;
	assign in_stall = q_full;
	assign filled   = (fill_q == FILL_W'(WINDOW_LEN));
	assign commit   = advance && valid_s2;
	assign push     = commit && filled;

	assign mag_s1 = spread_s1[SPREAD_W-1] ? PRICE_W'(-spread_s1) : PRICE_W'(spread_s1);

	// tail of the shift line is the oldest spread
	always_comb begin
		sum_d   = sum_q + SUM_W'(spread_s2);
		sumsq_d = sumsq_q + SUMSQ_W'(sq_s2);
		if (filled) begin
			sum_d   = sum_d - SUM_W'(win_spread_q[WINDOW_LEN-1]);
			sumsq_d = sumsq_d - SUMSQ_W'(win_sq_q[WINDOW_LEN-1]);
		end
	end

	assign dev = D_W'(spread_s2) * D_W'(WINDOW_LEN) - D_W'(sum_q);

	always_comb begin
		push_item.spread = spread_s2;
		push_item.dev    = dev;
		push_item.sum    = sum_q;
		push_item.sumsq  = sumsq_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			fill_q   <= '0;
			sum_q    <= '0;
			sumsq_q  <= '0;
		end else begin
			if (advance) begin
				valid_s1 <= in_valid;
				valid_s2 <= valid_s1;
			end
			if (commit) begin
				sum_q   <= sum_d;
				sumsq_q <= sumsq_d;
				if (!filled) begin
					fill_q <= fill_q + FILL_W'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			spread_s1 <= SPREAD_W'({1'b0, price_a}) - SPREAD_W'({1'b0, price_b});
			spread_s2 <= spread_s1;
			sq_s2     <= SQ_W'(mag_s1) * SQ_W'(mag_s1);
		end
		if (commit) begin
			win_spread_q[0] <= spread_s2;
			win_sq_q[0]     <= sq_s2;
			for (int i = 1; i < WINDOW_LEN; i++) begin
				win_spread_q[i] <= win_spread_q[i-1];
				win_sq_q[i]     <= win_sq_q[i-1];
			end
		end
	end

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		fill_q <= FILL_W'(WINDOW_LEN))
		else $error("fill count ran past the window length");

endmodule

[sv/rzs_fifo.sv]
// Short queue of scored words between the front end and the scoring back end.
// Depends on rzs_pkg for the word type and depth.
module rzs_fifo (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               push,
	input  rzs_pkg::rzs_item_t push_item,
	input  logic               pop,
	output rzs_pkg::rzs_item_t head,
	output logic               full,
	output logic               empty
);
	import rzs_pkg::*;

	rzs_item_t          mem_q [Q_DEPTH];
	logic [Q_PTR_W-1:0] wr_ptr_q;
	logic [Q_PTR_W-1:0] rd_ptr_q;
	logic [Q_CNT_W-1:0] cnt_q;

	assign full  = (cnt_q == Q_CNT_W'(Q_DEPTH));
	assign empty = (cnt_q == '0);
	assign head  = mem_q[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + Q_PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + Q_PTR_W'(1);
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + Q_CNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - Q_CNT_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_item;
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> !full)
		else $error("queue written while full");

	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> !empty)
		else $error("queue read while empty");

endmodule

[sv/rzs_back.sv]
// Back end: scores one queued word at a time with a shared 32x32 multiplier sequence,
// then hands the result to the output register. Depends on rzs_pkg.
module rzs_back (
	input  logic                       clk,
	input  logic                       arst_n,
	input  rzs_pkg::rzs_item_t         head,
	input  logic                       q_empty,
	output logic                       pop,
	input  logic [rzs_pkg::THR_W-1:0]  entry_thr,
	input  logic [rzs_pkg::THR_W-1:0]  exit_thr,
	output logic                       out_valid,
	input  logic                       out_stall,
	output logic [1:0]                 signal,
	output logic [rzs_pkg::SPREAD_W-1:0] spread_value
);
	import rzs_pkg::*;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_DD,
		ST_SQ,
		ST_V,
		ST_E2,
		ST_X2,
		ST_ENT_HI,
		ST_ENT,
		ST_EXT_HI,
		ST_EXT,
		ST_OUT
	} state_t;

	state_t              state_q;
	logic                out_valid_q;
	sig_t                signal_q;
	logic [SPREAD_W-1:0] spread_value_q;

	logic [SPREAD_W-1:0] spread_q;
	logic [D_W-1:0]      dev_q;
	logic [SUM_W-1:0]    sum_q;
	logic [SUMSQ_W-1:0]  sumsq_q;
	logic [PROD_W-1:0]   prod_q;
	logic [PROD_W-1:0]   acc_q;
	logic [PROD_W-1:0]   dd_q;
	logic [V_W-1:0]      v_q;
	logic [THR2_W-1:0]   e2_q;
	logic [THR2_W-1:0]   x2_q;
	logic [CMP_W-1:0]    ent_q;
	logic [CMP_W-1:0]    ext_q;

	logic [MUL_W-1:0]    op_a;
	logic [MUL_W-1:0]    op_b;
	logic [D_W-1:0]      dev_mag;
	logic [SUM_W-1:0]    sum_mag;
	logic [CMP_W-1:0]    dd_sh;
	logic                dev_pos;
	logic                dev_neg;
	sig_t                sig_d;
	logic                out_free;

	assign pop      = (state_q == ST_IDLE) && !q_empty;
	assign out_free = !out_valid_q || !out_stall;

	assign dev_mag = dev_q[D_W-1] ? D_W'(-dev_q) : dev_q;
	assign sum_mag = sum_q[SUM_W-1] ? SUM_W'(-sum_q) : sum_q;

	always_comb begin
		case (state_q)
			ST_DD: begin
				op_a = MUL_W'(dev_mag);
				op_b = MUL_W'(dev_mag);
			end
			ST_SQ: begin
				op_a = MUL_W'(sum_mag);
				op_b = MUL_W'(sum_mag);
			end
			ST_V: begin
				op_a = MUL_W'(entry_thr);
				op_b = MUL_W'(entry_thr);
			end
			ST_E2: begin
				op_a = MUL_W'(exit_thr);
				op_b = MUL_W'(exit_thr);
			end
			ST_X2: begin
				op_a = v_q[MUL_W-1:0];
				op_b = MUL_W'(e2_q);
			end
			ST_ENT_HI: begin
				op_a = MUL_W'(v_q[V_W-1:MUL_W]);
				op_b = MUL_W'(e2_q);
			end
			ST_ENT: begin
				op_a = v_q[MUL_W-1:0];
				op_b = MUL_W'(x2_q);
			end
			ST_EXT_HI: begin
				op_a = MUL_W'(v_q[V_W-1:MUL_W]);
				op_b = MUL_W'(x2_q);
			end
			default: begin
				op_a = '0;
				op_b = '0;
			end
		endcase
	end

	// z^2 against threshold^2, both sides scaled to integers
	assign dd_sh   = CMP_W'(dd_q) << Z_SHIFT;
	assign dev_pos = !dev_q[D_W-1] && (dev_q != '0);
	assign dev_neg = dev_q[D_W-1];

	always_comb begin
		if (dev_pos && (dd_sh > ent_q)) begin
			sig_d = SIG_LONG_SHORT;
		end else if (dev_neg && (dd_sh > ent_q)) begin
			sig_d = SIG_SHORT_LONG;
		end else if (dd_sh < ext_q) begin
			sig_d = SIG_CLOSE;
		end else begin
			sig_d = SIG_NONE;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			out_valid_q    <= 1'b0;
			signal_q       <= SIG_NONE;
			spread_value_q <= '0;
		end else begin
			if (out_valid_q && !out_stall && (state_q != ST_OUT)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (!q_empty) begin
						state_q <= ST_DD;
					end
				end
				ST_DD:     state_q <= ST_SQ;
				ST_SQ:     state_q <= ST_V;
				ST_V:      state_q <= ST_E2;
				ST_E2:     state_q <= ST_X2;
				ST_X2:     state_q <= ST_ENT_HI;
				ST_ENT_HI: state_q <= ST_ENT;
				ST_ENT:    state_q <= ST_EXT_HI;
				ST_EXT_HI: state_q <= ST_EXT;
				ST_EXT:    state_q <= ST_OUT;
				ST_OUT: begin
					if (out_free) begin
						out_valid_q    <= 1'b1;
						signal_q       <= sig_d;
						spread_value_q <= spread_q;
						state_q        <= ST_IDLE;
					end
				end
				default:   state_q <= ST_IDLE;
			endcase
		end
	end

	// datapath: prod_q always holds the product requested in the previous state
	always_ff @(posedge clk) begin
		prod_q <= PROD_W'(op_a) * PROD_W'(op_b);
		if (pop) begin
			spread_q <= head.spread;
			dev_q    <= head.dev;
			sum_q    <= head.sum;
			sumsq_q  <= head.sumsq;
		end
		case (state_q)
			ST_SQ:     dd_q  <= prod_q;
			ST_V:      v_q   <= V_W'(sumsq_q) * V_W'(WINDOW_LEN) - V_W'(prod_q);
			ST_E2:     e2_q  <= THR2_W'(prod_q);
			ST_X2:     x2_q  <= THR2_W'(prod_q);
			ST_ENT_HI: acc_q <= prod_q;
			ST_ENT:    ent_q <= CMP_W'(acc_q) + (CMP_W'(prod_q) << MUL_W);
			ST_EXT_HI: acc_q <= prod_q;
			ST_EXT:    ext_q <= CMP_W'(acc_q) + (CMP_W'(prod_q) << MUL_W);
			default: ;
		endcase
	end

	assign out_valid    = out_valid_q;
	assign signal       = signal_q;
	assign spread_value = spread_value_q;

	a_result_loaded: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_IDLE) && ($past(state_q) == ST_OUT) |-> out_valid_q)
		else $error("scored word finished without a result");

endmodule

[tb/sv/rolling_zscore_pair_signal_tb.sv]
// Self-checking testbench for rolling_zscore_pair_signal: random valid/stall traffic on both
// channels, a cycle-free predictor of the window sums and the squared z-score tests.
// Depends on rzs_pkg and the RTL of the block.
module rolling_zscore_pair_signal_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import rzs_pkg::*;

	localparam int PRICE_MAX     = (1 << PRICE_W) - 1;
	localparam int SETTLE_CYCLES = 48;
	localparam int PHASES        = 7;
	localparam int PHASE_ITEMS   = 155;

	typedef struct {
		logic [PRICE_W-1:0] pa;
		logic [PRICE_W-1:0] pb;
	} pair_t;

	typedef struct {
		sig_t                sig;
		logic [SPREAD_W-1:0] spread;
	} score_t;

	logic                 clk;
	logic                 arst_n = 1'b0;
	logic                 in_valid = 1'b0;
	logic                 in_stall;
	logic [PRICE_W-1:0]   price_a = '0;
	logic [PRICE_W-1:0]   price_b = '0;
	logic                 out_valid;
	logic                 out_stall = 1'b0;
	logic [1:0]           signal;
	logic [SPREAD_W-1:0]  spread_value;
	logic                 cfg_we = 1'b0;
	logic [CFG_IDX_W-1:0] cfg_index = REG_ENTRY;
	logic [THR_W-1:0]     cfg_data = '0;

	rolling_zscore_pair_signal dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.price_a      (price_a),
		.price_b      (price_b),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.signal       (signal),
		.spread_value (spread_value),
		.cfg_we       (cfg_we),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data)
	);

	always begin
		clk = 1'b1;
		#6;
		clk = 1'b0;
		#6;
	end

	// predictor state
	logic [THR_W-1:0]    entry_thr = ENTRY_RESET;
	logic [THR_W-1:0]    exit_thr  = EXIT_RESET;
	logic [SPREAD_W-1:0] win_spread [WINDOW_LEN] = '{default: '0};
	int unsigned         slot_ptr = 0;
	int unsigned         held = 0;
	logic signed [63:0]  win_sum = '0;
	logic [63:0]         win_sq = '0;

	pair_t  pending_pairs [$];
	score_t pending_scores [$];
	int     mismatches = 0;
	bit     quiet = 1'b0;

	// Scores one pair against the window as it stood, then rolls the pair into the window.
	// Returns 1 when the pair yields a result word.
	function automatic bit score_pair(input logic [PRICE_W-1:0] pa, input logic [PRICE_W-1:0] pb,
			output score_t res);
		logic signed [63:0] spr, old, dev;
		logic [127:0]       dmag, smag, dd, var_w, ent_lim, ext_lim;
		bit                 scored;
		spr = $signed({40'd0, pa}) - $signed({40'd0, pb});
		old = $signed(win_spread[slot_ptr]);
		scored = (held >= WINDOW_LEN);
		res.spread = spr[SPREAD_W-1:0];
		res.sig = SIG_NONE;
		if (scored) begin
			dev = WINDOW_LEN * spr - win_sum;
			dmag = 128'(dev < 0 ? -dev : dev);
			smag = 128'(win_sum < 0 ? -win_sum : win_sum);
			dd = (dmag * dmag) << Z_SHIFT;
			var_w = 128'(win_sq) * 128'(WINDOW_LEN) - smag * smag;
			ent_lim = var_w * (128'(entry_thr) * 128'(entry_thr));
			ext_lim = var_w * (128'(exit_thr) * 128'(exit_thr));
			if (dev > 0 && dd > ent_lim)
				res.sig = SIG_LONG_SHORT;
			else if (dev < 0 && dd > ent_lim)
				res.sig = SIG_SHORT_LONG;
			else if (dd < ext_lim)
				res.sig = SIG_CLOSE;
			win_sum = win_sum + spr - old;
			win_sq = win_sq + spr * spr - old * old;
		end else begin
			win_sum = win_sum + spr;
			win_sq = win_sq + spr * spr;
			held++;
		end
		win_spread[slot_ptr] = spr[SPREAD_W-1:0];
		slot_ptr = (slot_ptr + 1) % WINDOW_LEN;
		return scored;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t ns: %s: got %0h, expected %0h", $time, what, got, want);
		mismatches++;
	endtask

	// input side
	score_t      drv_score;
	pair_t       drv_next;
	int unsigned send_gap = 0;
	bit          send_calm = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && !in_stall) begin
				if (score_pair(price_a, price_b, drv_score))
					pending_scores.insert(pending_scores.size(), drv_score);
			end
			// a stalled word holds; otherwise pick idle or the next word
			if (!in_valid || !in_stall) begin
				if (send_gap != 0) begin
					send_gap--;
					in_valid <= 1'b0;
				end else if (!quiet && !send_calm && $urandom_range(0, 9) == 0) begin
					send_gap = $urandom_range(0, 13);
					in_valid <= 1'b0;
				end else if (pending_pairs.size() != 0) begin
					drv_next = pending_pairs.pop_front();
					in_valid <= 1'b1;
					price_a <= drv_next.pa;
					price_b <= drv_next.pb;
				end else begin
					in_valid <= 1'b0;
				end
			end
			if ($urandom_range(0, 199) == 0)
				send_calm = !send_calm;
		end
	end

	// output side
	score_t      mon_want;
	int unsigned stall_left = 0;
	bit          recv_calm = 1'b0;

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				if (pending_scores.size() == 0) begin
					report_mismatch("result word with none expected", 32'(signal),
						32'(spread_value));
				end else begin
					mon_want = pending_scores.pop_front();
					if (signal !== mon_want.sig)
						report_mismatch("signal", 32'(signal), 32'(mon_want.sig));
					if (spread_value !== mon_want.spread)
						report_mismatch("spread_value", 32'(spread_value),
							32'(mon_want.spread));
				end
			end
			if (stall_left != 0) begin
				stall_left--;
				out_stall <= 1'b1;
			end else if (!quiet && !recv_calm && $urandom_range(0, 7) == 0) begin
				stall_left = $urandom_range(0, 13);
				out_stall <= 1'b1;
			end else begin
				out_stall <= 1'b0;
			end
			if ($urandom_range(0, 199) == 0)
				recv_calm = !recv_calm;
		end
	end

	function automatic pair_t pair_for_spread(input int sp);
		pair_t w;
		if (sp > PRICE_MAX)
			sp = PRICE_MAX;
		if (sp < -PRICE_MAX)
			sp = -PRICE_MAX;
		if (sp >= 0) begin
			w.pb = PRICE_W'($urandom_range(0, PRICE_MAX - sp));
			w.pa = PRICE_W'(w.pb + sp);
		end else begin
			w.pa = PRICE_W'($urandom_range(0, PRICE_MAX + sp));
			w.pb = PRICE_W'(w.pa - sp);
		end
		return w;
	endfunction

	task automatic push_pair(input int pa, input int pb);
		pair_t w;
		w.pa = pa[PRICE_W-1:0];
		w.pb = pb[PRICE_W-1:0];
		pending_pairs.insert(pending_pairs.size(), w);
	endtask

	// Runs of words: mostly spreads wandering around a center, plus flat runs (zero
	// variance), spreads near zero, full-range prices and extremes.
	task automatic add_random(input int count);
		int    left, run, kind, center, scale, sp;
		pair_t w;
		left = count;
		while (left > 0) begin
			kind = $urandom_range(0, 19);
			run = $urandom_range(4, 40);
			if (run > left)
				run = left;
			center = int'($urandom_range(0, 2 * PRICE_MAX)) - PRICE_MAX;
			scale = 1 << $urandom_range(0, 20);
			repeat (run) begin
				if (kind < 2) begin
					w.pa = PRICE_W'($urandom_range(0, PRICE_MAX));
					w.pb = PRICE_W'($urandom_range(0, PRICE_MAX));
				end else begin
					if (kind < 13)
						sp = center + int'($urandom_range(0, 2 * scale)) - scale;
					else if (kind < 16)
						sp = center;
					else if (kind < 18)
						sp = int'($urandom_range(0, 2)) - 1;
					else
						case ($urandom_range(0, 2))
							0: sp = PRICE_MAX;
							1: sp = -PRICE_MAX;
							default: sp = 0;
						endcase
					w = pair_for_spread(sp);
				end
				pending_pairs.insert(pending_pairs.size(), w);
			end
			left -= run;
		end
	endtask

	task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [THR_W-1:0] val);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == REG_ENTRY)
			entry_thr = val;
		else if (idx == REG_EXIT)
			exit_thr = val;
	endtask

	// fill-only words give no result, so give the pipeline time to empty after the last one
	task automatic wait_idle();
		do
			@(negedge clk);
		while (pending_pairs.size() != 0 || in_valid || pending_scores.size() != 0);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	initial begin
		logic [THR_W-1:0] entry_set [PHASES];
		logic [THR_W-1:0] exit_set [PHASES];
		entry_set = '{12'd0, 12'd4095, 12'd4095, 12'd0, 12'd0, 12'd0, ENTRY_RESET};
		exit_set  = '{12'd0, 12'd4095, 12'd0, 12'd4095, 12'd0, 12'd0, EXIT_RESET};
		entry_set[4] = THR_W'($urandom_range(0, 4095));
		exit_set[4]  = THR_W'($urandom_range(0, 4095));
		entry_set[5] = THR_W'($urandom_range(1, 700));
		exit_set[5]  = THR_W'($urandom_range(1, 700));

		// fill with a flat window of zero spreads, some of them at the price extremes
		push_pair(0, 0);
		push_pair(PRICE_MAX, PRICE_MAX);
		push_pair(0, 0);
		push_pair(PRICE_MAX, PRICE_MAX);
		push_pair(5000, 5000);
		push_pair(PRICE_MAX, PRICE_MAX);
		push_pair(1, 1);
		push_pair(77, 77);
		// zero variance: no deviation and the largest positive deviation, then the largest negative spread
		push_pair(12345, 12345);
		push_pair(PRICE_MAX, 0);
		push_pair(0, PRICE_MAX);
		push_pair(0, 0);
		push_pair(1000, 900);
		push_pair(900, 1000);
		push_pair(2000, 1000);
		push_pair(1000, 2000);
		push_pair(PRICE_MAX, PRICE_MAX - 1);
		push_pair(0, 1);
		push_pair(8388608, 8388607);
		push_pair(8388607, 8388608);
		push_pair(PRICE_MAX, 0);

		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		wait_idle();

		for (int p = 0; p < PHASES; p++) begin
			write_reg(REG_ENTRY, entry_set[p]);
			write_reg(REG_EXIT, exit_set[p]);
			@(negedge clk);
			if (p == PHASES - 1)
				quiet = 1'b1;
			add_random(PHASE_ITEMS);
			wait_idle();
		end

		if (pending_scores.size() != 0)
			report_mismatch("result words never seen", 32'(pending_scores.size()), 32'd0);
		if (mismatches == 0)
			$display("rolling_zscore_pair_signal test passed");
		else
			$display("rolling_zscore_pair_signal test failed");
		$finish;
	end

	initial begin
		#5_000_000;
		$display("rolling_zscore_pair_signal test failed");
		$finish;
	end

endmodule
